// ----- sv/gamma_correct_mipmap_downsample_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the gamma-correct mipmap downsampler
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAMMA_CORRECT_MIPMAP_DOWNSAMPLE_DEFINES_SVH
`define GAMMA_CORRECT_MIPMAP_DOWNSAMPLE_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define GCMD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define GCMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/gcmd_pkg.sv -----
// ----------------------------------------------------------------------------
// gcmd_pkg
// Types, sizes and gamma tables shared by the mipmap downsampler modules.
// ----------------------------------------------------------------------------
package gcmd_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WID_W        = 12;
  localparam int CMP_W        = (WID_W > COL_W + 1) ? WID_W : COL_W + 1;

  localparam int MID_DEPTH    = 4;
  localparam int MID_PTR_W    = $clog2(MID_DEPTH);
  localparam int MID_CNT_W    = $clog2(MID_DEPTH + 1);

  localparam int OUT_DEPTH    = 16;
  localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

  localparam int NUM_COLOR    = 3;
  localparam int LIN_W        = 16;
  localparam int SUM_W        = LIN_W + 2;
  localparam int SEARCH_STEPS = 8;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // One complete 2x2 block: a, b from the stored even row, c, d from the odd row.
  typedef struct packed {
    pixel_t a;
    pixel_t b;
    pixel_t c;
    pixel_t d;
    logic   row_end;
  } quad_t;

  typedef struct packed {
    logic                 empty;
    logic [MID_CNT_W-1:0] count;
  } mid_status_t;

  typedef logic [LIN_W-1:0] lin_rom_t [256];
  typedef logic [16:0]      thr_rom_t [256];

  function automatic logic [255:0] big_pow(input logic [31:0] base, input int unsigned ex);
    logic [255:0] acc;
    acc = 256'd1;
    for (int e = 0; e < int'(ex); e++) begin
      acc = acc * {224'd0, base};
    end
    return acc;
  endfunction

  // n - 1/2 <= 65535 * ((v+1)/256)^2.2, compared as exact integer powers.
  function automatic logic fwd_ok(input logic [31:0] n, input logic [31:0] v);
    logic [255:0] lhs;
    logic [255:0] rhs;
    if (n == 32'd0) begin
      return 1'b1;
    end
    lhs = big_pow(2 * n - 1, 5) * big_pow(32'd256, 11);
    rhs = big_pow(v + 1, 11) * big_pow(32'd131070, 5);
    return lhs <= rhs;
  endfunction

  // k - 1/2 <= 255 * ((s+1)/65536)^(1/2.2), compared as exact integer powers.
  function automatic logic inv_ok(input logic [31:0] k, input logic [31:0] s);
    logic [255:0] lhs;
    logic [255:0] rhs;
    if (k == 32'd0) begin
      return 1'b1;
    end
    lhs = big_pow(2 * k - 1, 11) * big_pow(32'd65536, 5);
    rhs = big_pow(s + 1, 5) * big_pow(32'd510, 11);
    return lhs <= rhs;
  endfunction

  function automatic lin_rom_t build_lin();
    lin_rom_t     rom;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  mid;
    for (int v = 0; v < 256; v++) begin
      lo = 32'd0;
      hi = 32'd65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (fwd_ok(mid, 32'(v))) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      rom[v] = lo[LIN_W-1:0];
    end
    return rom;
  endfunction

  // Smallest linear sum that decodes to each output code; entry zero is zero.
  function automatic thr_rom_t build_thr();
    thr_rom_t     rom;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  mid;
    rom[0] = 17'd0;
    for (int k = 1; k < 256; k++) begin
      lo = 32'd0;
      hi = 32'd65536;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (inv_ok(32'(k), mid)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      rom[k] = lo[16:0];
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin();
  localparam thr_rom_t THR_ROM = build_thr();

endpackage

// ----- sv/gcmd_front.sv -----
// ----------------------------------------------------------------------------
// gcmd_front
// Tracks raster position, keeps the even row, and assembles 2x2 blocks.
// ----------------------------------------------------------------------------
module gcmd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [gcmd_pkg::WID_W-1:0]  cfg_wdata,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_start_of_image,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  input  logic [7:0]                  in_alpha,
  input  gcmd_pkg::mid_status_t       mid_status,
  output logic                        mid_push,
  output gcmd_pkg::quad_t             mid_quad
);

  logic [gcmd_pkg::WID_W-1:0] row_width_r;
  logic [gcmd_pkg::COL_W-1:0] col_r;
  logic [gcmd_pkg::COL_W-1:0] col_nxt;
  logic                       odd_r;
  logic                       odd_nxt;

  logic                       accept;
  logic [gcmd_pkg::COL_W-1:0] col_eff;
  logic                       odd_eff;
  logic [gcmd_pkg::CMP_W-1:0] width_raw;
  logic [gcmd_pkg::CMP_W-1:0] width_eff;
  logic [gcmd_pkg::CMP_W-1:0] width_even;
  logic [gcmd_pkg::CMP_W-1:0] col_ext;
  logic [gcmd_pkg::CMP_W-1:0] col_inc;
  logic                       in_range;
  logic                       store_wr;
  logic                       store_rd;
  gcmd_pkg::pixel_t           pix;

  gcmd_pkg::pixel_t           line_store [gcmd_pkg::MAX_WIDTH];
  gcmd_pkg::pixel_t           rd_data_r;
  gcmd_pkg::pixel_t           held_r;
  gcmd_pkg::pixel_t           upper_left_r;

  logic                       s1_valid_r;
  logic                       s1_odd_r;
  logic                       s1_row_end_r;
  gcmd_pkg::pixel_t           s1_pix_r;

  assign pix = '{alpha: in_alpha, blue: in_blue, green: in_green, red: in_red};

  // A pending block in the read stage counts against the queue space.
  assign full   = ({1'b0, mid_status.count} + (gcmd_pkg::MID_CNT_W + 1)'(s1_valid_r && s1_odd_r))
                  >= (gcmd_pkg::MID_CNT_W + 1)'(gcmd_pkg::MID_DEPTH);
  assign accept = push && !full;

  assign col_eff = in_start_of_image ? '0 : col_r;
  assign odd_eff = in_start_of_image ? 1'b0 : odd_r;

  always_comb begin
    width_raw = gcmd_pkg::CMP_W'(row_width_r);
    if (width_raw < gcmd_pkg::CMP_W'(2)) begin
      width_eff = gcmd_pkg::CMP_W'(2);
    end else if (width_raw > gcmd_pkg::CMP_W'(gcmd_pkg::MAX_WIDTH)) begin
      width_eff = gcmd_pkg::CMP_W'(gcmd_pkg::MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    width_even = width_eff & ~gcmd_pkg::CMP_W'(1);
  end

  assign col_ext  = gcmd_pkg::CMP_W'(col_eff);
  assign col_inc  = col_ext + gcmd_pkg::CMP_W'(1);
  assign in_range = col_ext < width_even;
  assign store_wr = accept && in_range && !odd_eff;
  assign store_rd = accept && in_range && odd_eff;

  always_comb begin
    if (col_inc >= width_eff) begin
      col_nxt = '0;
      odd_nxt = !odd_eff;
    end else begin
      col_nxt = col_inc[gcmd_pkg::COL_W-1:0];
      odd_nxt = odd_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= gcmd_pkg::WID_W'(2);
      col_r       <= '0;
      odd_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_width_r <= cfg_wdata;
      end
      if (accept) begin
        col_r <= col_nxt;
        odd_r <= odd_nxt;
      end
      s1_valid_r <= store_rd;
    end
  end

  // Line store: one write or one read per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (store_wr) begin
      line_store[col_eff] <= pix;
    end
    if (store_rd) begin
      rd_data_r <= line_store[col_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (store_rd) begin
      s1_odd_r     <= col_eff[0];
      s1_row_end_r <= col_ext == (width_even - gcmd_pkg::CMP_W'(1));
      s1_pix_r     <= pix;
    end
    if (store_rd && !col_eff[0]) begin
      held_r <= pix;
    end
    if (s1_valid_r && !s1_odd_r) begin
      upper_left_r <= rd_data_r;
    end
  end

  assign mid_push = s1_valid_r && s1_odd_r;
  assign mid_quad = '{a: upper_left_r, b: rd_data_r, c: held_r, d: s1_pix_r,
                      row_end: s1_row_end_r};

endmodule

// ----- sv/gcmd_quad_fifo.sv -----
// ----------------------------------------------------------------------------
// gcmd_quad_fifo
// Short queue of assembled 2x2 blocks between the front and back parts.
// ----------------------------------------------------------------------------
`include "gamma_correct_mipmap_downsample_defines.svh"

module gcmd_quad_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  gcmd_pkg::quad_t       wr_quad,
  input  logic                  rd_en,
  output gcmd_pkg::quad_t       rd_quad,
  output gcmd_pkg::mid_status_t status
);

  gcmd_pkg::quad_t                entries_r [gcmd_pkg::MID_DEPTH];
  logic [gcmd_pkg::MID_PTR_W-1:0] wr_ptr_r;
  logic [gcmd_pkg::MID_PTR_W-1:0] rd_ptr_r;
  logic [gcmd_pkg::MID_CNT_W-1:0] count_r;
  logic [gcmd_pkg::MID_CNT_W-1:0] count_nxt;

  assign count_nxt = count_r + gcmd_pkg::MID_CNT_W'(wr_en) - gcmd_pkg::MID_CNT_W'(rd_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + gcmd_pkg::MID_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + gcmd_pkg::MID_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_ptr_r] <= wr_quad;
    end
  end

  assign rd_quad      = entries_r[rd_ptr_r];
  assign status.empty = count_r == '0;
  assign status.count = count_r;

  `GCMD_ASSERT_ALWAYS(a_mid_no_overflow, !(wr_en && !rd_en && count_r == gcmd_pkg::MID_CNT_W'(gcmd_pkg::MID_DEPTH)), "block queue written while full")
  `GCMD_ASSERT_ALWAYS(a_mid_no_underflow, !(rd_en && count_r == '0), "block queue read while empty")
  `GCMD_ASSERT_NEXT(a_mid_ptr_gap, 1'b1, wr_ptr_r == rd_ptr_r + gcmd_pkg::MID_PTR_W'(count_r), "block queue pointers disagree with count")

endmodule

// ----- sv/gcmd_back.sv -----
// ----------------------------------------------------------------------------
// gcmd_back
// Gamma-correct averaging pipeline with the result queue behind it.
// ----------------------------------------------------------------------------
`include "gamma_correct_mipmap_downsample_defines.svh"

module gcmd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gcmd_pkg::mid_status_t mid_status,
  input  gcmd_pkg::quad_t       mid_quad,
  output logic                  mid_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic                  out_row_end
);

  localparam int NS = gcmd_pkg::SEARCH_STEPS;

  typedef struct packed {
    gcmd_pkg::pixel_t px;
    logic             row_end;
  } out_item_t;

  logic [gcmd_pkg::OUT_CNT_W-1:0] credit_r;
  logic [gcmd_pkg::OUT_CNT_W-1:0] credit_nxt;
  logic                           out_acc;
  gcmd_pkg::pixel_t               quad_px [4];

  logic                           l1_v_r;
  logic [gcmd_pkg::LIN_W-1:0]     lin_r [gcmd_pkg::NUM_COLOR][4];
  logic [7:0]                     l1_alpha_r;
  logic                           l1_end_r;

  logic [NS:0]                    srch_v_r;
  logic [gcmd_pkg::LIN_W-1:0]     srch_s_r [NS+1][gcmd_pkg::NUM_COLOR];
  logic [7:0]                     srch_k_r [NS+1][gcmd_pkg::NUM_COLOR];
  logic [7:0]                     srch_a_r [NS+1];
  logic                           srch_e_r [NS+1];

  out_item_t                      out_q_r [gcmd_pkg::OUT_DEPTH];
  logic [gcmd_pkg::OUT_PTR_W-1:0] out_wr_r;
  logic [gcmd_pkg::OUT_PTR_W-1:0] out_rd_r;
  logic [gcmd_pkg::OUT_CNT_W-1:0] out_cnt_r;
  logic                           out_push;
  out_item_t                      out_head;

  // Issue only when the result queue is sure to have room for the block.
  assign mid_pop    = !mid_status.empty
                      && (credit_r < gcmd_pkg::OUT_CNT_W'(gcmd_pkg::OUT_DEPTH));
  assign out_acc    = pop && !empty;
  assign credit_nxt = credit_r + gcmd_pkg::OUT_CNT_W'(mid_pop)
                      - gcmd_pkg::OUT_CNT_W'(out_acc);

  assign quad_px[0] = mid_quad.a;
  assign quad_px[1] = mid_quad.b;
  assign quad_px[2] = mid_quad.c;
  assign quad_px[3] = mid_quad.d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      l1_v_r   <= 1'b0;
      srch_v_r <= '0;
    end else begin
      credit_r <= credit_nxt;
      l1_v_r   <= mid_pop;
      srch_v_r <= {srch_v_r[NS-1:0], l1_v_r};
    end
  end

  // Linearize each color sample and average alpha directly.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < gcmd_pkg::NUM_COLOR; ch++) begin
      for (int p = 0; p < 4; p++) begin
        lin_r[ch][p] <= gcmd_pkg::LIN_ROM[quad_px[p][8*ch +: 8]];
      end
    end
    l1_alpha_r <= 8'((10'(quad_px[0].alpha) + 10'(quad_px[1].alpha)
                     + 10'(quad_px[2].alpha) + 10'(quad_px[3].alpha)) >> 2);
    l1_end_r   <= mid_quad.row_end;
  end

  // Sum the four linear values and start the code search at zero.
  always_ff @(posedge clk) begin
    logic [gcmd_pkg::SUM_W-1:0] sum;
    for (int ch = 0; ch < gcmd_pkg::NUM_COLOR; ch++) begin
      sum = gcmd_pkg::SUM_W'(lin_r[ch][0]) + gcmd_pkg::SUM_W'(lin_r[ch][1])
            + gcmd_pkg::SUM_W'(lin_r[ch][2]) + gcmd_pkg::SUM_W'(lin_r[ch][3]);
      srch_s_r[0][ch] <= sum[gcmd_pkg::SUM_W-1:2];
      srch_k_r[0][ch] <= 8'd0;
    end
    srch_a_r[0] <= l1_alpha_r;
    srch_e_r[0] <= l1_end_r;
  end

  // Binary search of the threshold table, one output bit per stage.
  for (genvar j = 1; j <= NS; j++) begin : g_search
    localparam logic [7:0] STEP_BIT = 8'd1 << (NS - j);
    always_ff @(posedge clk) begin
      logic [7:0] cand;
      for (int ch = 0; ch < gcmd_pkg::NUM_COLOR; ch++) begin
        cand = srch_k_r[j-1][ch] | STEP_BIT;
        if (gcmd_pkg::THR_ROM[cand] <= {1'b0, srch_s_r[j-1][ch]}) begin
          srch_k_r[j][ch] <= cand;
        end else begin
          srch_k_r[j][ch] <= srch_k_r[j-1][ch];
        end
        srch_s_r[j][ch] <= srch_s_r[j-1][ch];
      end
      srch_a_r[j] <= srch_a_r[j-1];
      srch_e_r[j] <= srch_e_r[j-1];
    end
  end

  // Result queue.
  assign out_push = srch_v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_wr_r  <= '0;
      out_rd_r  <= '0;
      out_cnt_r <= '0;
    end else begin
      if (out_push) begin
        out_wr_r <= out_wr_r + gcmd_pkg::OUT_PTR_W'(1);
      end
      if (out_acc) begin
        out_rd_r <= out_rd_r + gcmd_pkg::OUT_PTR_W'(1);
      end
      out_cnt_r <= out_cnt_r + gcmd_pkg::OUT_CNT_W'(out_push)
                   - gcmd_pkg::OUT_CNT_W'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_q_r[out_wr_r] <= '{px: '{alpha: srch_a_r[NS], blue: srch_k_r[NS][2],
                                   green: srch_k_r[NS][1], red: srch_k_r[NS][0]},
                             row_end: srch_e_r[NS]};
    end
  end

  assign out_head    = out_q_r[out_rd_r];
  assign empty       = out_cnt_r == '0;
  assign out_red     = out_head.px.red;
  assign out_green   = out_head.px.green;
  assign out_blue    = out_head.px.blue;
  assign out_alpha   = out_head.px.alpha;
  assign out_row_end = out_head.row_end;

  `GCMD_ASSERT_ALWAYS(a_credit_bound, credit_r <= gcmd_pkg::OUT_CNT_W'(gcmd_pkg::OUT_DEPTH), "issue credit beyond result queue depth")
  `GCMD_ASSERT_ALWAYS(a_out_no_overflow, !(out_push && !out_acc && out_cnt_r == gcmd_pkg::OUT_CNT_W'(gcmd_pkg::OUT_DEPTH)), "result queue written while full")
  `GCMD_ASSERT_ALWAYS(a_out_within_credit, out_cnt_r <= credit_r, "result queue holds more than was issued")

endmodule

// ----- sv/gamma_correct_mipmap_downsample.sv -----
// ----------------------------------------------------------------------------
// gamma_correct_mipmap_downsample
// Gamma-correct 2x2 box-filter mipmap downsampler for RGBA raster streams.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per transfer, and every complete 2x2
// block yields one half-size pixel; a trailing odd column or row is dropped.
// The block takes one pixel per clock cycle for as long as results are
// popped, since the line store is written on even rows and read on odd rows
// through its single port, one access per pixel. After the transfer of the
// pixel that completes its block, the block is assembled and written into
// the block queue; once issued, its colors are linearized and summed, the
// inverse gamma table is searched bit by bit, and the result is written into
// the result queue. The line store needs no clearing pass after reset; its
// entries are valid once the even row above has been written. Row width is
// set through cfg_we and cfg_wdata and should be changed only while idle.
// ----------------------------------------------------------------------------
module gamma_correct_mipmap_downsample (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration: row width in pixels.
  input  logic                        cfg_we,
  input  logic [gcmd_pkg::WID_W-1:0]  cfg_wdata,
  // Pixel input channel.
  input  logic                        push,
  output logic                        full,
  input  logic                        in_start_of_image,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  input  logic [7:0]                  in_alpha,
  // Downsampled pixel output channel.
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_alpha,
  output logic                        out_row_end
);

  // Block queue between the front and back parts.
  gcmd_pkg::mid_status_t mid_status;
  gcmd_pkg::quad_t       wr_quad;
  gcmd_pkg::quad_t       rd_quad;
  logic                  mid_push;
  logic                  mid_pop;

  // The front tracks position, stores the even row and builds blocks.
  gcmd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .push              (push),
    .full              (full),
    .in_start_of_image (in_start_of_image),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_alpha          (in_alpha),
    .mid_status        (mid_status),
    .mid_push          (mid_push),
    .mid_quad          (wr_quad)
  );

  // The queue lets the front keep accepting while the back waits on pops.
  gcmd_quad_fifo u_mid (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_push),
    .wr_quad (wr_quad),
    .rd_en   (mid_pop),
    .rd_quad (rd_quad),
    .status  (mid_status)
  );

  // The back filters each block in linear light and queues the result.
  gcmd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mid_status  (mid_status),
    .mid_quad    (rd_quad),
    .mid_pop     (mid_pop),
    .empty       (empty),
    .pop         (pop),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .out_row_end (out_row_end)
  );

endmodule
